[rtl/lpf_pkg.sv]
// ============================================================================
// lpf_pkg
// Shared types, constants and the control-word program of the lattice
// prediction filter.
// ============================================================================
`default_nettype none

package lpf_pkg;

    // Default parameter values
    localparam int unsigned MAX_ORDER_DEF   = 8;
    localparam int unsigned SAMPLE_BITS_DEF = 24;
    localparam int unsigned COEF_BITS_DEF   = 16;

    // Configuration port
    localparam int unsigned COEF_REG_W = 64;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ORDER    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_WORDS_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_WORDS_HIGH = 2'd3;

    localparam logic MODE_SYNTHESIS = 1'b0;
    localparam logic MODE_ANALYSIS  = 1'b1;

    // Control word fields
    typedef enum logic [1:0] {MUL_NONE, MUL_X, MUL_S} mul_src_t;
    typedef enum logic {ADD_A_X, ADD_A_S} add_a_t;
    typedef enum logic [1:0] {DST_NONE, DST_X, DST_T} add_dst_t;
    typedef enum logic [1:0] {SW_NONE, SW_T_AT_IDX, SW_SUM_ABOVE, SW_X_AT_ZERO} s_wr_t;
    typedef enum logic [1:0] {IDX_HOLD, IDX_INC, IDX_DEC} idx_op_t;
    typedef enum logic [1:0] {COND_NEVER, COND_MORE, COND_IDX_ZERO, COND_IDX_NONZERO} cond_t;

    localparam int unsigned UPC_W = 4;
    typedef logic [UPC_W-1:0] upc_t;

    typedef struct packed {
        mul_src_t mul_src;
        add_a_t   add_a;
        logic     add_sub;
        add_dst_t add_dst;
        s_wr_t    s_wr;
        idx_op_t  idx_op;
        cond_t    cond;
        upc_t     jump;
        logic     last;
    } ucode_t;

    // Program addresses
    localparam upc_t UPC_PASS    = 4'd0;
    localparam upc_t UPC_A_MULX  = 4'd1;
    localparam upc_t UPC_A_UPD   = 4'd2;
    localparam upc_t UPC_A_NEXT  = 4'd3;
    localparam upc_t UPC_A_MULS  = 4'd4;
    localparam upc_t UPC_A_FIN   = 4'd5;
    localparam upc_t UPC_Y_MULS  = 4'd6;
    localparam upc_t UPC_Y_XSUB  = 4'd7;
    localparam upc_t UPC_Y_MULS2 = 4'd8;
    localparam upc_t UPC_Y_XSUB2 = 4'd9;
    localparam upc_t UPC_Y_MULX  = 4'd10;
    localparam upc_t UPC_Y_SUPD  = 4'd11;
    localparam upc_t UPC_Y_END   = 4'd12;

    localparam ucode_t UW_NOP = '{
        mul_src: MUL_NONE, add_a: ADD_A_X, add_sub: 1'b0, add_dst: DST_NONE,
        s_wr: SW_NONE, idx_op: IDX_HOLD, cond: COND_NEVER, jump: UPC_PASS,
        last: 1'b0
    };

    // Sequencer states
    typedef enum logic [1:0] {SEQ_IDLE, SEQ_RUN, SEQ_DRAIN} seq_state_t;

    // Sequencer to datapath
    typedef struct packed {
        logic   load;
        logic   clear;
        logic   exec;
        ucode_t uw;
    } dp_ctl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic idx_zero;
        logic more;
    } dp_status_t;

    // Control store
    function automatic ucode_t ucode_rom(input upc_t a);
        ucode_t w;
        w = UW_NOP;
        unique case (a)
            UPC_PASS: begin
                w.last = 1'b1;
            end
            // analysis stage: P = c*x
            UPC_A_MULX: begin
                w.mul_src = MUL_X;
            end
            // t = sat(P + s), s = t, P = c*s
            UPC_A_UPD: begin
                w.mul_src = MUL_S;
                w.add_a   = ADD_A_S;
                w.add_dst = DST_T;
                w.s_wr    = SW_T_AT_IDX;
            end
            // x = sat(x + P), advance stage
            UPC_A_NEXT: begin
                w.add_a   = ADD_A_X;
                w.add_dst = DST_X;
                w.idx_op  = IDX_INC;
                w.cond    = COND_MORE;
                w.jump    = UPC_A_MULX;
            end
            UPC_A_MULS: begin
                w.mul_src = MUL_S;
            end
            UPC_A_FIN: begin
                w.add_a   = ADD_A_X;
                w.add_dst = DST_X;
                w.s_wr    = SW_T_AT_IDX;
                w.last    = 1'b1;
            end
            // synthesis: top stage
            UPC_Y_MULS: begin
                w.mul_src = MUL_S;
            end
            UPC_Y_XSUB: begin
                w.add_a   = ADD_A_X;
                w.add_sub = 1'b1;
                w.add_dst = DST_X;
                w.idx_op  = IDX_DEC;
                w.cond    = COND_IDX_ZERO;
                w.jump    = UPC_Y_END;
            end
            UPC_Y_MULS2: begin
                w.mul_src = MUL_S;
            end
            UPC_Y_XSUB2: begin
                w.add_a   = ADD_A_X;
                w.add_sub = 1'b1;
                w.add_dst = DST_X;
            end
            UPC_Y_MULX: begin
                w.mul_src = MUL_X;
            end
            // s[idx+1] = sat(P + s[idx]), step down
            UPC_Y_SUPD: begin
                w.add_a  = ADD_A_S;
                w.s_wr   = SW_SUM_ABOVE;
                w.idx_op = IDX_DEC;
                w.cond   = COND_IDX_NONZERO;
                w.jump   = UPC_Y_MULS2;
            end
            UPC_Y_END: begin
                w.s_wr = SW_X_AT_ZERO;
                w.last = 1'b1;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/lpf_datapath.sv]
// ============================================================================
// lpf_datapath
// Shared multiplier, saturating adder, lattice state and stage index.
// ============================================================================
`default_nettype none

module lpf_datapath #(
    parameter int unsigned MAX_ORDER   = lpf_pkg::MAX_ORDER_DEF,
    parameter int unsigned SAMPLE_BITS = lpf_pkg::SAMPLE_BITS_DEF,
    parameter int unsigned COEF_BITS   = lpf_pkg::COEF_BITS_DEF,
    localparam int unsigned ORD_W      = $clog2(MAX_ORDER + 1)
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire lpf_pkg::dp_ctl_t                      ctl,
    input  wire logic                                  mode,
    input  wire logic [ORD_W-1:0]                      n_eff,
    input  wire logic [lpf_pkg::COEF_REG_W-1:0]        coef_low,
    input  wire logic [lpf_pkg::COEF_REG_W-1:0]        coef_high,
    input  wire logic signed [SAMPLE_BITS-1:0]         sample_in,
    output logic signed [SAMPLE_BITS-1:0]              result,
    output lpf_pkg::dp_status_t                        status
);

    localparam int unsigned CW     = (COEF_BITS < 16) ? COEF_BITS : 16;
    localparam int unsigned IDX_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int unsigned CMP_W  = ORD_W + 1;
    localparam int unsigned PROD_W = CW + SAMPLE_BITS;
    localparam int unsigned RP_W   = SAMPLE_BITS + 1;
    localparam int unsigned SUM_W  = SAMPLE_BITS + 2;
    localparam logic signed [PROD_W-1:0] RND_K = PROD_W'(2 ** (CW - 2));
    localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] t_reg;
    logic signed [RP_W-1:0]        p_reg;
    logic signed [RP_W-1:0]        p_next;
    logic [IDX_W-1:0]              idx_reg;
    logic [IDX_W-1:0]              idx_next;
    logic signed [SAMPLE_BITS-1:0] s_reg [MAX_ORDER];

    logic signed [SAMPLE_BITS-1:0] s_rd;
    logic [2*lpf_pkg::COEF_REG_W-1:0] coef_all;
    logic [4:0]                    cidx;
    logic [6:0]                    cbase;
    logic signed [CW-1:0]          coef_v;
    logic signed [SAMPLE_BITS-1:0] mul_b;
    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      prod_rnd;
    logic signed [SAMPLE_BITS-1:0] add_a_val;
    logic signed [SUM_W-1:0]       a_ext;
    logic signed [SUM_W-1:0]       p_ext;
    logic signed [SUM_W-1:0]       sum;
    logic [2:0]                    sum_hi;
    logic signed [SAMPLE_BITS-1:0] sum_sat;
    logic                          s_we;
    logic [IDX_W-1:0]              s_waddr;
    logic signed [SAMPLE_BITS-1:0] s_wdata;
    logic [CMP_W-1:0]              idx_ext;

    assign s_rd = s_reg[idx_reg];

    // coefficient of the current stage; stages past the eighth get zero
    assign coef_all = {coef_high, coef_low};
    assign cidx     = 5'(idx_reg);
    assign cbase    = {cidx[2:0], 4'b0000};
    assign coef_v   = (cidx < 5'd8) ? $signed(coef_all[cbase +: CW]) : '0;

    // one rounded product per step
    assign mul_b    = (ctl.uw.mul_src == lpf_pkg::MUL_X) ? x_reg : s_rd;
    assign prod     = coef_v * mul_b;
    assign prod_rnd = prod + RND_K;
    assign p_next   = prod_rnd[PROD_W-1:CW-1];

    // one saturating add per step
    assign add_a_val = (ctl.uw.add_a == lpf_pkg::ADD_A_S) ? s_rd : x_reg;
    assign a_ext     = SUM_W'(add_a_val);
    assign p_ext     = SUM_W'(p_reg);
    assign sum       = ctl.uw.add_sub ? (a_ext - p_ext) : (a_ext + p_ext);
    assign sum_hi    = sum[SUM_W-1:SAMPLE_BITS-1];

    always_comb
    begin
        if ((&sum_hi) || !(|sum_hi))
        begin
            sum_sat = sum[SAMPLE_BITS-1:0];
        end
        else
        begin
            sum_sat = sum[SUM_W-1] ? $signed(SAT_MIN) : $signed(SAT_MAX);
        end
    end

    // state write port
    always_comb
    begin
        s_we    = ctl.exec;
        s_waddr = idx_reg;
        s_wdata = t_reg;
        unique case (ctl.uw.s_wr)
            lpf_pkg::SW_NONE:      s_we = 1'b0;
            lpf_pkg::SW_T_AT_IDX:  s_wdata = t_reg;
            lpf_pkg::SW_SUM_ABOVE:
            begin
                s_waddr = IDX_W'(idx_reg + 1'b1);
                s_wdata = sum_sat;
            end
            lpf_pkg::SW_X_AT_ZERO:
            begin
                s_waddr = '0;
                s_wdata = x_reg;
            end
            default: s_we = 1'b0;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.load)
        begin
            idx_next = (mode == lpf_pkg::MODE_ANALYSIS) ? '0 : IDX_W'(n_eff - 1'b1);
        end
        else if (ctl.exec)
        begin
            unique case (ctl.uw.idx_op)
                lpf_pkg::IDX_HOLD: idx_next = idx_reg;
                lpf_pkg::IDX_INC:  idx_next = IDX_W'(idx_reg + 1'b1);
                lpf_pkg::IDX_DEC:  idx_next = IDX_W'(idx_reg - 1'b1);
                default:           idx_next = idx_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < MAX_ORDER; e++)
            begin
                s_reg[e] <= '0;
            end
        end
        else if (ctl.load && ctl.clear)
        begin
            for (int e = 0; e < MAX_ORDER; e++)
            begin
                s_reg[e] <= '0;
            end
        end
        else if (s_we)
        begin
            for (int e = 0; e < MAX_ORDER; e++)
            begin
                if (s_waddr == IDX_W'(e))
                begin
                    s_reg[e] <= s_wdata;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            x_reg <= sample_in;
            t_reg <= sample_in;
        end
        else if (ctl.exec)
        begin
            if (ctl.uw.add_dst == lpf_pkg::DST_X)
            begin
                x_reg <= sum_sat;
            end
            if (ctl.uw.add_dst == lpf_pkg::DST_T)
            begin
                t_reg <= sum_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec && ctl.uw.mul_src != lpf_pkg::MUL_NONE)
        begin
            p_reg <= p_next;
        end
    end

    assign idx_ext         = CMP_W'(idx_reg);
    assign status.idx_zero = (idx_reg == '0);
    assign status.more     = (idx_ext + CMP_W'(2)) < CMP_W'(n_eff);
    assign result          = x_reg;

endmodule

`default_nettype wire

[rtl/lpf_sequencer.sv]
// ============================================================================
// lpf_sequencer
// Step counter over the control store, with conditional jumps and the
// idle / run / drain control of one line at a time.
// ============================================================================
`default_nettype none

module lpf_sequencer #(
    parameter int unsigned MAX_ORDER = lpf_pkg::MAX_ORDER_DEF,
    localparam int unsigned ORD_W    = $clog2(MAX_ORDER + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic                 clear_in,
    input  wire logic                 mode,
    input  wire logic [ORD_W-1:0]     n_eff,
    input  wire lpf_pkg::dp_status_t  dp_st,
    input  wire logic                 out_free,
    output logic                      ready,
    output logic                      push,
    output lpf_pkg::dp_ctl_t          ctl
);

    lpf_pkg::seq_state_t state_reg;
    lpf_pkg::seq_state_t state_next;
    lpf_pkg::upc_t       upc_reg;
    lpf_pkg::upc_t       upc_next;
    lpf_pkg::upc_t       start_upc;
    lpf_pkg::ucode_t     uw;
    logic                take;

    assign uw = lpf_pkg::ucode_rom(upc_reg);

    always_comb
    begin
        unique case (uw.cond)
            lpf_pkg::COND_NEVER:       take = 1'b0;
            lpf_pkg::COND_MORE:        take = dp_st.more;
            lpf_pkg::COND_IDX_ZERO:    take = dp_st.idx_zero;
            lpf_pkg::COND_IDX_NONZERO: take = !dp_st.idx_zero;
            default:                   take = 1'b0;
        endcase
    end

    // entry point from mode and order
    always_comb
    begin
        priority if (n_eff == '0)
        begin
            start_upc = lpf_pkg::UPC_PASS;
        end
        else if (mode == lpf_pkg::MODE_ANALYSIS)
        begin
            start_upc = (n_eff == ORD_W'(1)) ? lpf_pkg::UPC_A_MULS : lpf_pkg::UPC_A_MULX;
        end
        else
        begin
            start_upc = lpf_pkg::UPC_Y_MULS;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lpf_pkg::SEQ_IDLE:  if (accept) state_next = lpf_pkg::SEQ_RUN;
            lpf_pkg::SEQ_RUN:   if (uw.last) state_next = lpf_pkg::SEQ_DRAIN;
            lpf_pkg::SEQ_DRAIN: if (out_free) state_next = lpf_pkg::SEQ_IDLE;
            default:            state_next = lpf_pkg::SEQ_IDLE;
        endcase
    end

    always_comb
    begin
        upc_next = upc_reg;
        if (accept)
        begin
            upc_next = start_upc;
        end
        else if (state_reg == lpf_pkg::SEQ_RUN)
        begin
            upc_next = take ? uw.jump : lpf_pkg::upc_t'(upc_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpf_pkg::SEQ_IDLE;
            upc_reg   <= lpf_pkg::UPC_PASS;
        end
        else
        begin
            state_reg <= state_next;
            upc_reg   <= upc_next;
        end
    end

    always_comb
    begin
        ready     = (state_reg == lpf_pkg::SEQ_IDLE);
        push      = (state_reg == lpf_pkg::SEQ_DRAIN) && out_free;
        ctl.load  = accept;
        ctl.clear = clear_in;
        ctl.exec  = (state_reg == lpf_pkg::SEQ_RUN);
        ctl.uw    = uw;
    end

endmodule

`default_nettype wire

[rtl/lattice_prediction_filter.sv]
// ============================================================================
// lattice_prediction_filter
// Reflection-coefficient lattice filter for spectral lines: analysis (FIR)
// or synthesis (IIR), order 0 to MAX_ORDER, driven by a small control store.
// ============================================================================
// One line is in flight at a time. Lines enter on the s_ stream and leave on
// the m_ stream in order, one result per line. The pace is set by the
// single multiplier and single saturating adder that every lattice step goes
// through: analysis needs up to three control steps per stage, synthesis
// up to four. The result sits in an output register, so the next line is
// taken as soon as the previous one has been moved there, even while the
// consumer stalls. Orders above MAX_ORDER act as MAX_ORDER. Stages past the
// eighth use a zero coefficient. Products are rounded to nearest (halves up)
// and every sum saturates to SAMPLE_BITS. Write the configuration registers
// only while the block is idle; lattice state survives across lines until
// reset or a line with the clear flag (tuser) set.
`default_nettype none

module lattice_prediction_filter #(
    parameter int unsigned MAX_ORDER   = lpf_pkg::MAX_ORDER_DEF,
    parameter int unsigned SAMPLE_BITS = lpf_pkg::SAMPLE_BITS_DEF,
    parameter int unsigned COEF_BITS   = lpf_pkg::COEF_BITS_DEF,
    localparam int unsigned DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [DATA_W-1:0]                  s_tdata,   // sample_in, zero fill
    input  wire logic                               s_tuser,   // clear_state
    input  wire logic                               s_tlast,   // last_line
    // output stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [DATA_W-1:0]                       m_tdata,   // sample_out, zero fill
    output logic                                    m_tlast,   // last_out
    // configuration
    input  wire logic                               cfg_we,
    input  wire logic [lpf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lpf_pkg::COEF_REG_W-1:0]     cfg_data
);

    localparam int unsigned ORD_W = $clog2(MAX_ORDER + 1);

    // configuration registers
    logic                            mode_reg;
    logic [3:0]                      order_reg;
    logic [lpf_pkg::COEF_REG_W-1:0]  coef_low_reg;
    logic [lpf_pkg::COEF_REG_W-1:0]  coef_high_reg;

    // output word register
    logic                            out_valid_reg;
    logic [DATA_W-1:0]               out_data_reg;
    logic                            out_last_reg;
    logic                            last_hold_reg;

    logic [4:0]                      order_ext;
    logic [ORD_W-1:0]                n_eff;
    logic                            accept;
    logic                            out_free;
    logic                            push;
    logic                            ready;
    logic signed [SAMPLE_BITS-1:0]   result;
    lpf_pkg::dp_ctl_t                ctl;
    lpf_pkg::dp_status_t             dp_st;

    // Apply a register write; the port has no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= lpf_pkg::MODE_SYNTHESIS;
            order_reg     <= '0;
            coef_low_reg  <= '0;
            coef_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lpf_pkg::CFG_FILTER_MODE:     mode_reg      <= cfg_data[0];
                lpf_pkg::CFG_FILTER_ORDER:    order_reg     <= cfg_data[3:0];
                lpf_pkg::CFG_COEF_WORDS_LOW:  coef_low_reg  <= cfg_data;
                lpf_pkg::CFG_COEF_WORDS_HIGH: coef_high_reg <= cfg_data;
                default:                      mode_reg      <= mode_reg;
            endcase
        end
    end

    // Clamp the order to the stages that exist
    assign order_ext = {1'b0, order_reg};
    assign n_eff     = (order_ext > 5'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : ORD_W'(order_ext);

    assign s_tready = ready;
    assign accept   = s_tvalid && ready;
    assign out_free = !out_valid_reg || m_tready;

    lpf_sequencer #(
        .MAX_ORDER (MAX_ORDER)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .clear_in (s_tuser),
        .mode     (mode_reg),
        .n_eff    (n_eff),
        .dp_st    (dp_st),
        .out_free (out_free),
        .ready    (ready),
        .push     (push),
        .ctl      (ctl)
    );

    lpf_datapath #(
        .MAX_ORDER   (MAX_ORDER),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .mode      (mode_reg),
        .n_eff     (n_eff),
        .coef_low  (coef_low_reg),
        .coef_high (coef_high_reg),
        .sample_in ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .result    (result),
        .status    (dp_st)
    );

    // Hold the region flag of the line in flight
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_hold_reg <= s_tlast;
        end
    end

    // Advance the finished line into the output word; drop the valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_data_reg <= DATA_W'($unsigned(result));
            out_last_reg <= last_hold_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

[rtl/lpf_checker.sv]
// ============================================================================
// lpf_checker
// Port-level checks of the lattice prediction filter, bound to the top level.
// ============================================================================
`default_nettype none

module lpf_checker #(
    parameter int unsigned DATA_W = 24
) (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [DATA_W-1:0]              m_tdata,
    input wire logic                           m_tlast
);

    // a stalled output word stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // one line at a time: no second word right after an accepted one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a line is in flight");

    // a new result only appears while the input side is closed
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a line in flight");

    // a result cannot show up in the cycle right after an acceptance
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared one cycle after acceptance");

endmodule

bind lattice_prediction_filter lpf_checker #(.DATA_W(DATA_W)) u_lpf_checker (.*);

`default_nettype wire

[sim/testbench.sv]
// ============================================================================
// testbench
// Self-checking bench for lattice_prediction_filter: streams spectral lines
// through analysis and synthesis lattices of varied order, predicts each
// filtered word in a bit-exact fixed-point lattice of its own, and compares
// field by field under random idling, stalls and a long output hold-off.
// ============================================================================
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     SW        = 24;
    localparam int     ORDER_CAP = 8;
    localparam longint LINE_MAX  = 64'sd8388607;
    localparam longint LINE_MIN  = -64'sd8388608;

    // one filtered word as it should leave the block
    typedef struct packed {
        logic [SW-1:0] sample;
        logic          last;
    } line_t;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [SW-1:0] s_tdata;    // sample_in
    logic          s_tuser;    // clear_state
    logic          s_tlast;    // last_line
    logic          m_tvalid;
    logic          m_tready;
    logic [SW-1:0] m_tdata;    // sample_out
    logic          m_tlast;    // last_out
    logic          cfg_we;
    logic [lpf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lpf_pkg::COEF_REG_W-1:0] cfg_data;

    // Mirror of the register file and of the lattice delay line
    logic        cur_mode;
    logic [3:0]  cur_order;
    logic [63:0] cur_coef_lo;
    logic [63:0] cur_coef_hi;
    longint      lattice_s [ORDER_CAP];

    line_t pending_lines [$];
    int    mismatches   = 0;

    // Traffic shaping
    bit   src_idle_on   = 1'b0;
    logic sink_stall_on = 1'b0;
    logic sink_hold_go  = 1'b0;
    int   sink_wait     = 0;

    lattice_prediction_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Fixed-point lattice predictor
    // ------------------------------------------------------------------------

    // Saturate a running sum to the sample width.
    function automatic longint clip(input longint v);
        if (v > LINE_MAX)
            return LINE_MAX;
        if (v < LINE_MIN)
            return LINE_MIN;
        return v;
    endfunction

    // Q1.15 product, rounded to nearest with halves going up.
    function automatic longint rmul(input longint c, input longint v);
        return (c * v + 64'sd16384) >>> 15;
    endfunction

    function automatic longint coef_at(input int k);
        logic [63:0]        w;
        logic signed [15:0] h;
        w = (k < 4) ? cur_coef_lo : cur_coef_hi;
        h = w[16 * (k % 4) +: 16];
        return longint'(h);
    endfunction

    // Advance the mirrored lattice by one line; return the filtered line.
    function automatic logic [SW-1:0] filter_line(input logic [SW-1:0] smp,
                                                  input logic clr);
        longint x;
        longint t;
        longint u;
        longint c;
        int     n;
        x = longint'($signed(smp));
        if (clr)
            foreach (lattice_s[i])
                lattice_s[i] = 0;
        // orders past the lattice depth act as the full lattice
        n = (cur_order > ORDER_CAP) ? ORDER_CAP : int'(cur_order);
        if (n > 0)
        begin
            if (cur_mode == lpf_pkg::MODE_ANALYSIS)
            begin
                // forward error runs up, backward error shifts into the state
                t = x;
                for (int i = 0; i < n - 1; i++)
                begin
                    c = coef_at(i);
                    u = clip(rmul(c, x) + lattice_s[i]);
                    x = clip(x + rmul(c, lattice_s[i]));
                    lattice_s[i] = t;
                    t = u;
                end
                x = clip(x + rmul(coef_at(n - 1), lattice_s[n - 1]));
                lattice_s[n - 1] = t;
            end
            else
            begin
                // all-pole inverse: peel stages from the top down
                x = clip(x - rmul(coef_at(n - 1), lattice_s[n - 1]));
                for (int i = n - 1; i > 0; i--)
                begin
                    c = coef_at(i - 1);
                    x = clip(x - rmul(c, lattice_s[i - 1]));
                    lattice_s[i] = clip(rmul(c, x) + lattice_s[i - 1]);
                end
                lattice_s[0] = x;
            end
        end
        return x[SW-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Random content
    // ------------------------------------------------------------------------

    function automatic logic [SW-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return $urandom_range(0, 1) ? 24'h000000 : 24'hFFFFFF;
            3, 4:    return SW'(int'($urandom_range(0, 4000)) - 2000);
            default: return SW'($urandom);
        endcase
    endfunction

    // Four Q1.15 halves: some moderate, some at +/-1.0, some fully random.
    function automatic logic [63:0] rand_coef_word();
        logic [63:0] w;
        for (int k = 0; k < 4; k++)
        begin
            case ($urandom_range(0, 5))
                0:       w[16 * k +: 16] = 16'h7FFF;
                1:       w[16 * k +: 16] = 16'h8000;
                2, 3:    w[16 * k +: 16] = 16'(int'($urandom_range(0, 16384)) - 8192);
                default: w[16 * k +: 16] = 16'($urandom);
            endcase
        end
        return w;
    endfunction

    function automatic logic [3:0] rand_order();
        case ($urandom_range(0, 9))
            0:       return 4'd0;
            1:       return 4'($urandom_range(9, 15));
            default: return 4'($urandom_range(1, ORDER_CAP));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------

    // Write all four registers on consecutive edges. Unused high bits of the
    // mode and order words carry junk, which the block must drop.
    task automatic configure(input logic mode, input logic [3:0] order,
                             input logic [63:0] lo, input logic [63:0] hi);
        logic [63:0] mode_w;
        logic [63:0] order_w;
        mode_w       = {$urandom, $urandom};
        mode_w[0]    = mode;
        order_w      = {$urandom, $urandom};
        order_w[3:0] = order;
        cfg_we    <= 1'b1;
        cfg_index <= lpf_pkg::CFG_FILTER_MODE;
        cfg_data  <= mode_w;
        @(posedge clk);
        cfg_index <= lpf_pkg::CFG_FILTER_ORDER;
        cfg_data  <= order_w;
        @(posedge clk);
        cfg_index <= lpf_pkg::CFG_COEF_WORDS_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= lpf_pkg::CFG_COEF_WORDS_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_we      <= 1'b0;
        cur_mode    = mode;
        cur_order   = order;
        cur_coef_lo = lo;
        cur_coef_hi = hi;
    endtask

    // Offer one line; predict its result once the handshake completes.
    // Valid stays high after acceptance so back-to-back words need no toggle.
    task automatic send_line(input logic [SW-1:0] smp, input logic clr,
                             input logic lst);
        line_t want;
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= clr;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        want.sample = filter_line(smp, clr);
        want.last   = lst;
        pending_lines.push_back(want);
    endtask

    // Drop valid and hold until every predicted word has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_lines.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Output side: ready with random stall bursts, plus a long hold on request
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (sink_hold_go)
        begin
            m_tready  <= 1'b0;
            sink_wait <= 400;
        end
        else if (sink_wait > 0)
        begin
            m_tready  <= 1'b0;
            sink_wait <= sink_wait - 1;
        end
        else if (sink_stall_on && $urandom_range(0, 4) == 0)
        begin
            m_tready  <= 1'b0;
            sink_wait <= $urandom_range(0, 6);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Compare every accepted word against the oldest prediction.
    always @(posedge clk)
    begin
        line_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_lines.size() == 0)
            begin
                $error("unexpected word: sample_out %0d, last_out %0b",
                       $signed(m_tdata), m_tlast);
                mismatches++;
            end
            else
            begin
                want = pending_lines.pop_front();
                if (m_tdata !== want.sample)
                begin
                    $error("sample_out mismatch: expected %0d, actual %0d",
                           $signed(want.sample), $signed(m_tdata));
                    mismatches++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_out mismatch: expected %0b, actual %0b",
                           want.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset registers give order 0; then order 0 in both modes with extremes.
    task automatic test_pass_through();
        send_line(24'h7FFFFF, 1'b0, 1'b0);
        send_line(24'h800000, 1'b1, 1'b1);
        wait_drained();
        configure(lpf_pkg::MODE_ANALYSIS, 4'd0, rand_coef_word(), rand_coef_word());
        send_line(24'h000000, 1'b0, 1'b1);
        send_line(24'hFFFFFF, 1'b1, 1'b0);
        wait_drained();
        configure(lpf_pkg::MODE_SYNTHESIS, 4'd0, rand_coef_word(), rand_coef_word());
        send_line(24'h555555, 1'b0, 1'b0);
        send_line(24'hAAAAAA, 1'b0, 1'b1);
        wait_drained();
    endtask

    // Full-depth lattices with the lower four coefficients at +/-1.0 to drive saturation
    // of sums and state, starting from a cleared delay line.
    task automatic test_lattice_extremes();
        logic [63:0] lo;
        logic [63:0] hi;
        lo = 64'h7FFF_8000_7FFF_8000;
        hi = 64'hFFFF_0001_C000_4000;
        configure(lpf_pkg::MODE_ANALYSIS, 4'd8, lo, hi);
        send_line(24'h7FFFFF, 1'b1, 1'b0);
        send_line(24'h800000, 1'b0, 1'b0);
        send_line(24'h7FFFFF, 1'b0, 1'b0);
        send_line(24'h800000, 1'b0, 1'b0);
        send_line(24'h000001, 1'b0, 1'b1);
        wait_drained();
        configure(lpf_pkg::MODE_SYNTHESIS, 4'd8, 64'h7FFF_7FFF_7FFF_7FFF, hi);
        send_line(24'h7FFFFF, 1'b1, 1'b0);
        send_line(24'h7FFFFF, 1'b0, 1'b0);
        send_line(24'h800000, 1'b0, 1'b0);
        send_line(24'h000000, 1'b0, 1'b1);
        send_line(24'hFFFFFF, 1'b1, 1'b0);
        wait_drained();
    endtask

    // Single stage in both modes, then orders past the lattice depth.
    task automatic test_order_edges();
        configure(lpf_pkg::MODE_ANALYSIS, 4'd1, 64'h0000_0000_0000_8000, 64'd0);
        send_line(24'h7FFFFF, 1'b1, 1'b0);
        send_line(24'h400000, 1'b0, 1'b1);
        wait_drained();
        configure(lpf_pkg::MODE_SYNTHESIS, 4'd1, 64'h0000_0000_0000_7FFF, 64'd0);
        send_line(24'h800000, 1'b0, 1'b0);
        send_line(24'h123456, 1'b0, 1'b0);
        wait_drained();
        configure(lpf_pkg::MODE_ANALYSIS, 4'd9, rand_coef_word(), rand_coef_word());
        send_line(rand_sample(), 1'b0, 1'b0);
        send_line(rand_sample(), 1'b0, 1'b0);
        wait_drained();
        configure(lpf_pkg::MODE_SYNTHESIS, 4'd15, rand_coef_word(), rand_coef_word());
        send_line(rand_sample(), 1'b0, 1'b0);
        send_line(rand_sample(), 1'b0, 1'b1);
        wait_drained();
    endtask

    // Random settings per phase, each phase a stream of lines with an
    // occasional frame-start clear and region end.
    task automatic test_random_phases(input int phases, input int lines);
        for (int p = 0; p < phases; p++)
        begin
            configure(1'($urandom_range(0, 1)), rand_order(),
                      rand_coef_word(), rand_coef_word());
            for (int k = 0; k < lines; k++)
                send_line(rand_sample(), $urandom_range(0, 15) == 0,
                          $urandom_range(0, 7) == 0);
            wait_drained();
        end
    endtask

    // Hold the output off for a long stretch while lines keep coming, so the
    // block fills and stalls its input.
    task automatic test_backpressure();
        configure(lpf_pkg::MODE_SYNTHESIS, 4'd8, rand_coef_word(), rand_coef_word());
        sink_hold_go <= 1'b1;
        @(posedge clk);
        sink_hold_go <= 1'b0;
        for (int k = 0; k < 40; k++)
            send_line(rand_sample(), k == 0, $urandom_range(0, 7) == 0);
        wait_drained();
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_full_rate();
        src_idle_on   = 1'b0;
        sink_stall_on <= 1'b0;
        configure(lpf_pkg::MODE_ANALYSIS, 4'd8, rand_coef_word(), rand_coef_word());
        for (int k = 0; k < 30; k++)
            send_line(rand_sample(), k == 0, $urandom_range(0, 7) == 0);
        wait_drained();
        configure(lpf_pkg::MODE_SYNTHESIS, 4'($urandom_range(1, ORDER_CAP)),
                  rand_coef_word(), rand_coef_word());
        for (int k = 0; k < 30; k++)
            send_line(rand_sample(), $urandom_range(0, 15) == 0,
                      $urandom_range(0, 7) == 0);
        wait_drained();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = lpf_pkg::CFG_FILTER_MODE;
        cfg_data  = '0;
        // register file and lattice come out of reset cleared
        cur_mode    = lpf_pkg::MODE_SYNTHESIS;
        cur_order   = 4'd0;
        cur_coef_lo = '0;
        cur_coef_hi = '0;
        foreach (lattice_s[i])
            lattice_s[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_pass_through();
        test_lattice_extremes();
        test_order_edges();
        src_idle_on   = 1'b1;
        sink_stall_on <= 1'b1;
        test_random_phases(14, 50);
        test_backpressure();
        test_full_rate();

        // let any stray word show up before the verdict
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("[lattice_prediction_filter] OK");
        else
            $display("[lattice_prediction_filter] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("[lattice_prediction_filter] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
